// ----- rtl/pfba_pkg.sv -----
// Shared types, constants and helpers of the page-frame bitmap allocator.
// No dependencies; imported by pfba_ctrl, pfba_dp, the top level and the testbench.
package pfba_pkg;

  localparam int Frames     = 4096;
  localparam int MapBytes   = (Frames + 7) / 8;
  localparam int FullBytes  = Frames / 8;
  localparam int MapAw      = $clog2(MapBytes);
  localparam int FrameW     = $clog2(Frames);
  localparam int FrameShift = 12;
  localparam int AddrW      = 32;
  localparam int CfgW       = 13;
  localparam int CountW     = 13;
  localparam int PtrW       = CfgW - 2;
  localparam int InDataW    = 32;
  localparam int OutDataW   = 48;

  localparam logic [CountW-1:0] CountMax = {CountW{1'b1}};
  localparam logic [7:0]        ByteFull = 8'hFF;

  typedef enum logic [0:0] {
    CfgFirstFrame = 1'b0,
    CfgFrameLimit = 1'b1
  } pfba_cfg_e;

  typedef enum logic [0:0] {
    CmdAlloc = 1'b0,
    CmdFree  = 1'b1
  } pfba_op_e;

  typedef enum logic [1:0] {
    StDone    = 2'd0,
    StNoFree  = 2'd1,
    StOutside = 2'd2
  } pfba_status_e;

  typedef struct packed {
    logic cap;
    logic rd;
    logic inc;
    logic clr_wr;
    logic alloc_wr;
    logic free_wr;
    logic none;
    logic outside;
  } pfba_cmd_t;

  typedef struct packed {
    logic op_free;
    logic outside;
    logic clr_last;
    logic scan_done;
    logic byte_full;
    logic out_free;
  } pfba_stat_t;

  function automatic logic [2:0] lowest_zero(input logic [7:0] v);
    logic [2:0] idx;
    idx = 3'd0;
    for (int i = 7; i >= 0; i--) begin
      if (!v[i]) idx = 3'(i);
    end
    return idx;
  endfunction

endpackage

// ----- rtl/pfba_ram.sv -----
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module pfba_ram #(
  parameter int Width = 8,
  parameter int Depth = 512
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) mem_q[waddr_i] <= wdata_i;
    if (re_i) rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

// ----- rtl/pfba_ctrl.sv -----
// Sequencer of the allocator: clearing pass, command decode, byte scan.
// Depends on pfba_pkg; drives pfba_dp through pfba_cmd_t.
module pfba_ctrl
  import pfba_pkg::*;
(
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_ready_o,
  input  pfba_stat_t stat_i,
  output pfba_cmd_t  cmd_o
);

  typedef enum logic [2:0] {
    SClear,
    SIdle,
    SLook,
    SChkAlloc,
    SChkFree,
    SFinNone,
    SFinOutside
  } state_e;

  state_e state_q, state_d;

  always_comb begin
    state_d    = state_q;
    cmd_o      = '0;
    in_ready_o = 1'b0;
    unique case (state_q)
      SClear: begin
        cmd_o.clr_wr = 1'b1;
        cmd_o.inc    = 1'b1;
        if (stat_i.clr_last) state_d = SIdle;
      end
      SIdle: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.cap = 1'b1;
          state_d   = SLook;
        end
      end
      SLook: begin
        if (stat_i.op_free) begin
          if (stat_i.outside) begin
            state_d = SFinOutside;
          end else begin
            cmd_o.rd = 1'b1;
            state_d  = SChkFree;
          end
        end else if (stat_i.scan_done) begin
          state_d = SFinNone;
        end else begin
          cmd_o.rd = 1'b1;
          state_d  = SChkAlloc;
        end
      end
      SChkAlloc: begin
        if (stat_i.byte_full) begin
          cmd_o.inc = 1'b1;
          state_d   = SLook;
        end else if (stat_i.out_free) begin
          cmd_o.alloc_wr = 1'b1;
          state_d        = SIdle;
        end
      end
      SChkFree: begin
        if (stat_i.out_free) begin
          cmd_o.free_wr = 1'b1;
          state_d       = SIdle;
        end
      end
      SFinNone: begin
        if (stat_i.out_free) begin
          cmd_o.none = 1'b1;
          state_d    = SIdle;
        end
      end
      SFinOutside: begin
        if (stat_i.out_free) begin
          cmd_o.outside = 1'b1;
          state_d       = SIdle;
        end
      end
      default: state_d = SIdle;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= SClear;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

// ----- rtl/pfba_dp.sv -----
// Datapath of the allocator: config registers, bitmap RAM, scan pointer,
// frame count and output register. Depends on pfba_pkg and pfba_ram.
module pfba_dp
  import pfba_pkg::*;
(
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                cfg_we_i,
  input  logic                cfg_index_i,
  input  logic [CfgW-1:0]     cfg_wdata_i,
  input  logic [InDataW-1:0]  in_data_i,
  input  logic                in_user_i,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output logic [OutDataW-1:0] out_data_o,
  output logic [1:0]          out_user_o,
  input  pfba_cmd_t           cmd_i,
  output pfba_stat_t          stat_o
);

  logic [CfgW-1:0]   first_q, limit_q;
  logic [PtrW-1:0]   ptr_q, ptr_d;
  logic [PtrW-1:0]   start_w, end_w;
  logic [CfgW:0]     first_rnd;
  logic [CountW-1:0] count_q, count_d;
  logic              op_q;
  logic [AddrW-1:0]  addr_q;
  logic              out_vld_q;
  logic [AddrW-1:0]  out_addr_q;
  logic [1:0]        out_st_q;
  logic [CountW-1:0] out_cnt_q;

  logic [MapAw-1:0]  free_byte;
  logic [2:0]        free_bit, alloc_bit;
  logic [7:0]        rdata;
  logic [MapAw-1:0]  raddr, waddr;
  logic [7:0]        wdata;
  logic              we;
  logic              out_load;
  logic [AddrW-1:0]  alloc_addr;

  assign first_rnd = {1'b0, first_q} + (CfgW+1)'(7);
  assign start_w   = first_rnd[CfgW:3];
  always_comb begin
    end_w = PtrW'(limit_q[CfgW-1:3]);
    if (end_w > PtrW'(FullBytes)) end_w = PtrW'(FullBytes);
  end

  assign free_byte = addr_q[FrameShift+FrameW-1 -: MapAw];
  assign free_bit  = addr_q[FrameShift+2:FrameShift];
  assign alloc_bit = lowest_zero(rdata);
  assign alloc_addr = AddrW'({ptr_q[MapAw-1:0], alloc_bit, {FrameShift{1'b0}}});

  assign raddr = op_q ? free_byte : ptr_q[MapAw-1:0];
  assign we    = cmd_i.clr_wr | cmd_i.alloc_wr | cmd_i.free_wr;
  assign waddr = cmd_i.free_wr ? free_byte : ptr_q[MapAw-1:0];

  always_comb begin
    wdata = 8'h00;
    if (cmd_i.alloc_wr) wdata = rdata | (8'h01 << alloc_bit);
    if (cmd_i.free_wr)  wdata = rdata & ~(8'h01 << free_bit);
  end

  pfba_ram #(
    .Width(8),
    .Depth(MapBytes)
  ) u_map (
    .clk_i  (clk_i),
    .we_i   (we),
    .waddr_i(waddr),
    .wdata_i(wdata),
    .re_i   (cmd_i.rd),
    .raddr_i(raddr),
    .rdata_o(rdata)
  );

  always_comb begin
    ptr_d = ptr_q;
    if (cmd_i.cap)      ptr_d = start_w;
    else if (cmd_i.inc) ptr_d = ptr_q + PtrW'(1);
  end

  always_comb begin
    count_d = count_q;
    if (cmd_i.alloc_wr && count_q != CountMax)    count_d = count_q + CountW'(1);
    if (cmd_i.free_wr && count_q != CountW'(0))  count_d = count_q - CountW'(1);
  end

  assign out_load = cmd_i.alloc_wr | cmd_i.free_wr | cmd_i.none | cmd_i.outside;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      first_q   <= '0;
      limit_q   <= CfgW'(Frames);
      ptr_q     <= '0;
      count_q   <= '0;
      out_vld_q <= 1'b0;
    end else begin
      if (cfg_we_i && cfg_index_i == CfgFirstFrame) first_q <= cfg_wdata_i;
      if (cfg_we_i && cfg_index_i == CfgFrameLimit) limit_q <= cfg_wdata_i;
      ptr_q   <= ptr_d;
      count_q <= count_d;
      if (out_load)         out_vld_q <= 1'b1;
      else if (out_ready_i) out_vld_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.cap) begin
      op_q   <= in_user_i;
      addr_q <= in_data_i;
    end
    if (out_load) begin
      out_addr_q <= cmd_i.alloc_wr ? alloc_addr : '0;
      out_cnt_q  <= count_d;
      priority if (cmd_i.none)    out_st_q <= StNoFree;
      else if (cmd_i.outside)     out_st_q <= StOutside;
      else                        out_st_q <= StDone;
    end
  end

  assign stat_o.op_free   = (op_q == CmdFree);
  assign stat_o.outside   = (addr_q[AddrW-1:FrameShift+FrameW] != '0);
  assign stat_o.clr_last  = (ptr_q[MapAw-1:0] == MapAw'(MapBytes - 1));
  assign stat_o.scan_done = (ptr_q >= end_w);
  assign stat_o.byte_full = (rdata == ByteFull);
  assign stat_o.out_free  = !out_vld_q || out_ready_i;

  assign out_valid_o = out_vld_q;
  assign out_data_o  = {(OutDataW-AddrW-CountW)'(0), out_cnt_q, out_addr_q};
  assign out_user_o  = out_st_q;

endmodule

// ----- rtl/page_frame_bitmap_allocator_core.sv -----
// Page-frame bitmap allocator, top level.
// Depends on pfba_pkg, pfba_ctrl, pfba_dp (which holds pfba_ram).
//
// Usage:
//   Commands arrive on the s_axis channel, one beat each: tuser selects
//   allocate (0) or free (1), tdata carries the byte address to free.
//   Each command yields one result beat on m_axis: tdata carries the
//   allocated frame address and the frame count, tuser the status
//   (done, no free frame, freed frame outside the store). The user writes
//   first_frame and frame_limit via cfg_we_i while idle, unchecked by the block.
// Operation:
//   A free in the store reads its frame's bitmap byte, then clears its bit;
//   an allocation reads one bitmap byte at a time and checks it after each read,
//   until a byte holds a clear bit or the scan ends. One command is in work at a
//   time; s_axis_tready is high again once the result is registered.
// Reset and stall:
//   After reset the bitmap RAM is cleared one byte per cycle, all 512 bytes,
//   with s_axis_tready low. A stalled m_axis beat holds; the block may
//   accept the next command meanwhile and waits to register its result
//   until the output register is free.
module page_frame_bitmap_allocator_core
  import pfba_pkg::*;
(
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                cfg_we_i,
  input  logic                cfg_index_i,
  input  logic [CfgW-1:0]     cfg_wdata_i,
  input  logic                s_axis_tvalid,
  output logic                s_axis_tready,
  // [31:0] free_address
  input  logic [InDataW-1:0]  s_axis_tdata,
  // [0] command
  input  logic                s_axis_tuser,
  output logic                m_axis_tvalid,
  input  logic                m_axis_tready,
  // [31:0] frame_address, [44:32] frames_in_use, [47:45] zero
  output logic [OutDataW-1:0] m_axis_tdata,
  // [1:0] status
  output logic [1:0]          m_axis_tuser
);

  pfba_cmd_t  cmd;
  pfba_stat_t stat;

  pfba_ctrl u_ctrl (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .in_valid_i(s_axis_tvalid),
    .in_ready_o(s_axis_tready),
    .stat_i    (stat),
    .cmd_o     (cmd)
  );

  pfba_dp u_dp (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_index_i(cfg_index_i),
    .cfg_wdata_i(cfg_wdata_i),
    .in_data_i  (s_axis_tdata),
    .in_user_i  (s_axis_tuser),
    .out_valid_o(m_axis_tvalid),
    .out_ready_i(m_axis_tready),
    .out_data_o (m_axis_tdata),
    .out_user_o (m_axis_tuser),
    .cmd_i      (cmd),
    .stat_o     (stat)
  );

endmodule

// ----- test/testbench.sv -----
// Self-checking testbench for page_frame_bitmap_allocator_core: drives allocate and free beats,
// predicts each result from a private copy of the frame bitmap and checks every result beat.
// Depends on pfba_pkg and the RTL of the allocator.
module testbench;
  import pfba_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int IdleLimit = 20000;
  localparam int HoldCycles = 400;

  typedef struct packed {
    logic [AddrW-1:0]  frame_address;
    logic [1:0]        status;
    logic [CountW-1:0] frames_in_use;
  } alloc_result_t;

  class frame_ledger;
    logic [7:0]        used_map[MapBytes];
    logic [CountW-1:0] in_use;
    logic [CfgW-1:0]   first_frame;
    logic [CfgW-1:0]   frame_limit;
    alloc_result_t     pending_results[$];
    int                errors;

    function new();
      foreach (used_map[b]) used_map[b] = 8'h00;
      in_use = '0;
      first_frame = '0;
      frame_limit = CfgW'(Frames);
      errors = 0;
    endfunction

    function void set_register(pfba_cfg_e idx, logic [CfgW-1:0] value);
      if (idx == CfgFirstFrame) first_frame = value;
      else frame_limit = value;
    endfunction

    function void note_command(pfba_op_e op, logic [AddrW-1:0] addr);
      alloc_result_t r;
      int start_byte;
      int end_byte;
      bit found;
      logic [AddrW-FrameShift-1:0] frame;
      r.frame_address = '0;
      r.status = StNoFree;
      if (op == CmdAlloc) begin
        start_byte = (int'(first_frame) + 7) >> 3;
        end_byte = int'(frame_limit) >> 3;
        if (end_byte > FullBytes) end_byte = FullBytes;
        found = 1'b0;
        for (int b = start_byte; b < end_byte && !found; b++) begin
          for (int i = 0; i < 8 && !found; i++) begin
            if (!used_map[b][i]) begin
              used_map[b][i] = 1'b1;
              if (in_use != CountMax) in_use = in_use + 1'b1;
              r.frame_address = AddrW'(b * 8 + i) << FrameShift;
              r.status = StDone;
              found = 1'b1;
            end
          end
        end
      end else begin
        frame = addr >> FrameShift;
        if (frame >= Frames) begin
          r.status = StOutside;
        end else begin
          used_map[frame >> 3][frame[2:0]] = 1'b0;
          if (in_use != '0) in_use = in_use - 1'b1;
          r.status = StDone;
        end
      end
      r.frames_in_use = in_use;
      pending_results.push_back(r);
    endfunction

    function void check_result(logic [OutDataW-1:0] data, logic [1:0] status);
      alloc_result_t want;
      if (pending_results.size() == 0) begin
        $display("%0t: unexpected result beat, tdata %h status %0d", $time, data, status);
        errors++;
        return;
      end
      want = pending_results.pop_front();
      if (data[31:0] !== want.frame_address) begin
        $display("%0t: frame_address expected %h actual %h", $time, want.frame_address,
                 data[31:0]);
        errors++;
      end
      if (status !== want.status) begin
        $display("%0t: status expected %0d actual %0d", $time, want.status, status);
        errors++;
      end
      if (data[44:32] !== want.frames_in_use) begin
        $display("%0t: frames_in_use expected %0d actual %0d", $time, want.frames_in_use,
                 data[44:32]);
        errors++;
      end
    endfunction
  endclass

  logic                clk_i = 1'b0;
  logic                rst_ni;
  logic                cfg_we_i;
  logic                cfg_index_i;
  logic [CfgW-1:0]     cfg_wdata_i;
  logic                s_axis_tvalid;
  logic                s_axis_tready;
  logic [InDataW-1:0]  s_axis_tdata;
  logic                s_axis_tuser;
  logic                m_axis_tvalid;
  logic                m_axis_tready;
  logic [OutDataW-1:0] m_axis_tdata;
  logic [1:0]          m_axis_tuser;

  frame_ledger ledger = new();
  bit          steady = 1'b0;
  bit          hold_request = 1'b0;
  int          idle_cycles = 0;

  page_frame_bitmap_allocator_core dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_we_i     (cfg_we_i),
    .cfg_index_i  (cfg_index_i),
    .cfg_wdata_i  (cfg_wdata_i),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .s_axis_tuser (s_axis_tuser),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata),
    .m_axis_tuser (m_axis_tuser)
  );

  always begin
    #4 clk_i = 1'b1;
    #4 clk_i = 1'b0;
  end

  task automatic send_command(input pfba_op_e op, input logic [AddrW-1:0] addr);
    if (!steady && $urandom_range(0, 99) < 36) begin
      s_axis_tvalid <= 1'b0;
      repeat ($urandom_range(1, 4)) @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tuser  <= op;
    s_axis_tdata  <= addr;
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
    ledger.note_command(op, addr);
  endtask

  task automatic drain();
    s_axis_tvalid <= 1'b0;
    while (ledger.pending_results.size() != 0) @(posedge clk_i);
    repeat (8) @(posedge clk_i);
  endtask

  task automatic configure(input logic [CfgW-1:0] first, input logic [CfgW-1:0] limit);
    cfg_we_i    <= 1'b1;
    cfg_index_i <= CfgFirstFrame;
    cfg_wdata_i <= first;
    @(posedge clk_i);
    ledger.set_register(CfgFirstFrame, first);
    cfg_index_i <= CfgFrameLimit;
    cfg_wdata_i <= limit;
    @(posedge clk_i);
    ledger.set_register(CfgFrameLimit, limit);
    cfg_we_i <= 1'b0;
    @(posedge clk_i);
  endtask

  task automatic run_phase(input logic [CfgW-1:0] first, input logic [CfgW-1:0] limit,
                           input int count, input bit hold);
    int lo;
    int hi;
    int pick;
    logic [AddrW-1:0] addr;
    drain();
    configure(first, limit);
    lo = (int'(first) < Frames) ? int'(first) : Frames - 1;
    hi = ((int'(limit) < Frames) ? int'(limit) : Frames) - 1;
    if (hi < lo) begin
      lo = 0;
      hi = Frames - 1;
    end
    if (hold) hold_request = 1'b1;
    for (int n = 0; n < count; n++) begin
      pick = $urandom_range(0, 99);
      if (pick < 55) begin
        send_command(CmdAlloc, $urandom());
      end else begin
        if (pick < 90)
          addr = (AddrW'($urandom_range(lo, hi)) << FrameShift) | ($urandom() & 32'hFFF);
        else
          addr = $urandom();
        send_command(CmdFree, addr);
      end
    end
  endtask

  initial begin : stimulus
    logic [CfgW-1:0] first_pick;
    logic [CfgW-1:0] limit_pick;
    rst_ni        <= 1'b0;
    cfg_we_i      <= 1'b0;
    cfg_index_i   <= CfgFirstFrame;
    cfg_wdata_i   <= '0;
    s_axis_tvalid <= 1'b0;
    s_axis_tdata  <= '0;
    s_axis_tuser  <= CmdAlloc;
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
    configure(13'd0, 13'd4096);

    send_command(CmdAlloc, 32'h0);
    send_command(CmdAlloc, 32'hFFFF_FFFF);
    send_command(CmdAlloc, 32'h0);
    send_command(CmdFree, 32'h0000_1FFF);
    send_command(CmdAlloc, 32'h0);
    send_command(CmdFree, 32'h00FF_F000);
    send_command(CmdFree, 32'hFFFF_FFFF);
    send_command(CmdFree, 32'h0100_0000);
    send_command(CmdFree, 32'h0000_0000);
    send_command(CmdFree, 32'h0000_0000);
    send_command(CmdFree, 32'h0000_2000);
    send_command(CmdFree, 32'h0000_1000);
    send_command(CmdFree, 32'h0000_1000);
    drain();
    configure(13'd4096, 13'd4096);
    send_command(CmdAlloc, 32'h0);
    send_command(CmdFree, 32'h00FF_FFFF);
    drain();
    configure(13'd100, 13'd50);
    send_command(CmdAlloc, 32'h0);
    drain();
    configure(13'd8191, 13'd0);
    send_command(CmdAlloc, 32'h0);
    drain();
    configure(13'd4088, 13'd8191);
    repeat (9) send_command(CmdAlloc, 32'h0);

    steady = 1'b1;
    run_phase(13'd0, 13'd4096, 200, 1'b0);
    steady = 1'b0;
    first_pick = CfgW'($urandom_range(0, 4096));
    run_phase(first_pick, first_pick + CfgW'($urandom_range(8, 80)), 120, 1'b0);
    first_pick = CfgW'($urandom_range(0, 4000));
    run_phase(first_pick, first_pick + 13'd64, 150, 1'b1);
    for (int p = 0; p < 6; p++) begin
      case (p % 3)
        0: begin
          first_pick = CfgW'($urandom_range(0, 4096));
          limit_pick = first_pick + CfgW'($urandom_range(8, 96));
        end
        1: begin
          first_pick = CfgW'($urandom_range(3900, 4096));
          limit_pick = CfgW'($urandom_range(4097, 8191));
        end
        default: begin
          first_pick = CfgW'($urandom());
          limit_pick = CfgW'($urandom());
        end
      endcase
      run_phase(first_pick, limit_pick, 110, 1'b0);
    end

    drain();
    repeat (20) @(posedge clk_i);
    if (ledger.errors == 0) begin
      $display("page_frame_bitmap_allocator_core test passed");
    end else begin
      $display("page_frame_bitmap_allocator_core test failed");
    end
    $finish;
  end

  initial begin : result_sink
    m_axis_tready <= 1'b0;
    forever begin
      @(posedge clk_i);
      if (hold_request) begin
        hold_request = 1'b0;
        m_axis_tready <= 1'b0;
        repeat (HoldCycles) @(posedge clk_i);
      end
      m_axis_tready <= steady || ($urandom_range(0, 99) >= 36);
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      ledger.check_result(m_axis_tdata, m_axis_tuser);
    end
  end

  always @(posedge clk_i) begin
    if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= IdleLimit) begin
        $display("page_frame_bitmap_allocator_core test failed");
        $finish;
      end
    end
  end

endmodule

// ----- files.f -----
rtl/pfba_pkg.sv
rtl/pfba_ram.sv
rtl/pfba_ctrl.sv
rtl/pfba_dp.sv
rtl/page_frame_bitmap_allocator_core.sv
test/testbench.sv
